>>> sv/sdf_pkg.sv
// Shared types, constants and helpers for the signed distance block.
// No dependencies; every file but sdf_if imports this package.
package sdf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 63;

  localparam logic signed [31:0] DIST_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] DIST_MIN = -32'sh7fffffff - 32'sd1;
  localparam logic signed [31:0] Q_ONE    = 32'sd1 <<< FRAC_BITS;

  // Shape kinds held in the kind register
  typedef enum logic [2:0] {
    KIND_SPHERE = 3'd0,
    KIND_BOX    = 3'd1,
    KIND_CYL    = 3'd2,
    KIND_CONE   = 3'd3,
    KIND_TORUS  = 3'd4,
    KIND_PLANE  = 3'd5
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KIND    = 3'd0,
    REG_PARAM_A = 3'd1,
    REG_PARAM_B = 3'd2,
    REG_PARAM_C = 3'd3,
    REG_PARAM_D = 3'd4
  } reg_idx_t;

  // Per-item data that rides alongside the long arithmetic units
  typedef struct packed {
    logic [2:0]          kind;
    logic                fin;   // final value already known
    logic signed [31:0]  res;   // saturated result when fin is set
    logic signed [34:0]  aux;   // box min term, cylinder dy, cone axial term
    logic signed [31:0]  y;     // point y for the torus
    logic signed [63:0]  num;   // cone dividend
  } side_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'(DIST_MAX)) begin
      return DIST_MAX;
    end else if (v < 68'(DIST_MIN)) begin
      return DIST_MIN;
    end
    return v[31:0];
  endfunction

  // Magnitude of a 32-bit signed value
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    if (v[31]) begin
      return 32'(~v) + 32'd1;
    end
    return v;
  endfunction

endpackage

>>> sv/sdf_if.sv
// Handshake channels for points in and distances out.
// Depends on nothing; payload widths are fixed by the word format.
interface sdf_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sdf_dist_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] distance;
  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

>>> sv/sdf_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on sdf_pkg for the stage count and the side data type.
module sdf_isqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [63:0]   rad,
  input  sdf_pkg::side_t in_side,
  output logic          out_v,
  output logic [31:0]   root,
  output sdf_pkg::side_t out_side
);
  import sdf_pkg::*;

  logic        v_q   [SQRT_STAGES];
  logic [63:0] n_q   [SQRT_STAGES];
  logic [63:0] r_q   [SQRT_STAGES];
  side_t       s_q   [SQRT_STAGES];
  logic        v_src [SQRT_STAGES];
  logic [63:0] n_src [SQRT_STAGES];
  logic [63:0] r_src [SQRT_STAGES];
  side_t       s_src [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [63:0] bit_k;
    logic [63:0] trial;

    // Take the word from the input or from the stage before
    if (k == 0) begin : g_first
      assign v_src[k] = in_v;
      assign n_src[k] = rad;
      assign r_src[k] = '0;
      assign s_src[k] = in_side;
    end else begin : g_next
      assign v_src[k] = v_q[k-1];
      assign n_src[k] = n_q[k-1];
      assign r_src[k] = r_q[k-1];
      assign s_src[k] = s_q[k-1];
    end

    assign bit_k = 64'd1 << (62 - 2 * k);
    assign trial = r_src[k] + bit_k;

    // Settle one root bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_src[k];
      end
      if (en) begin
        s_q[k] <= s_src[k];
        if (n_src[k] >= trial) begin
          n_q[k] <= n_src[k] - trial;
          r_q[k] <= (r_src[k] >> 1) + bit_k;
        end else begin
          n_q[k] <= n_src[k];
          r_q[k] <= r_src[k] >> 1;
        end
      end
    end
  end

  assign out_v    = v_q[SQRT_STAGES-1];
  assign root     = r_q[SQRT_STAGES-1][31:0];
  assign out_side = s_q[SQRT_STAGES-1];

endmodule

>>> sv/sdf_div.sv
// Pipelined signed division truncating toward zero, one quotient bit per stage.
// Depends on sdf_pkg for the stage count and the side data type.
module sdf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  logic signed [63:0] dividend,
  input  logic signed [32:0] divisor,
  input  sdf_pkg::side_t     in_side,
  output logic               out_v,
  output logic signed [63:0] quot,
  output sdf_pkg::side_t     out_side
);
  import sdf_pkg::*;

  logic        v_q    [DIV_STAGES];
  logic [62:0] n_q    [DIV_STAGES];
  logic [31:0] rem_q  [DIV_STAGES];
  logic [62:0] q_q    [DIV_STAGES];
  logic [31:0] d_q    [DIV_STAGES];
  logic        neg_q  [DIV_STAGES];
  side_t       s_q    [DIV_STAGES];
  logic        v_src  [DIV_STAGES];
  logic [62:0] n_src  [DIV_STAGES];
  logic [31:0] rem_src[DIV_STAGES];
  logic [62:0] q_src  [DIV_STAGES];
  logic [31:0] d_src  [DIV_STAGES];
  logic        neg_src[DIV_STAGES];
  side_t       s_src  [DIV_STAGES];

  logic [63:0] num_mag;
  logic [32:0] den_mag;

  // Split operands into magnitudes and a result sign
  assign num_mag = dividend[63] ? 64'(-dividend) : 64'(dividend);
  assign den_mag = divisor[32] ? 33'(-divisor) : 33'(divisor);

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_src[k]   = in_v;
      assign n_src[k]   = num_mag[62:0];
      assign rem_src[k] = '0;
      assign q_src[k]   = '0;
      assign d_src[k]   = den_mag[31:0];
      assign neg_src[k] = dividend[63] ^ divisor[32];
      assign s_src[k]   = in_side;
    end else begin : g_next
      assign v_src[k]   = v_q[k-1];
      assign n_src[k]   = n_q[k-1];
      assign rem_src[k] = rem_q[k-1];
      assign q_src[k]   = q_q[k-1];
      assign d_src[k]   = d_q[k-1];
      assign neg_src[k] = neg_q[k-1];
      assign s_src[k]   = s_q[k-1];
    end

    assign trial = {rem_src[k], n_src[k][62]};
    assign ge    = trial >= {1'b0, d_src[k]};

    // Shift in one dividend bit and subtract where it fits
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_src[k];
      end
      if (en) begin
        n_q[k]   <= {n_src[k][61:0], 1'b0};
        rem_q[k] <= ge ? 32'(trial - {1'b0, d_src[k]}) : trial[31:0];
        q_q[k]   <= {q_src[k][61:0], ge};
        d_q[k]   <= d_src[k];
        neg_q[k] <= neg_src[k];
        s_q[k]   <= s_src[k];
      end
    end
  end

  assign out_v    = v_q[DIV_STAGES-1];
  assign quot     = neg_q[DIV_STAGES-1] ? -$signed({1'b0, q_q[DIV_STAGES-1]})
                                        : $signed({1'b0, q_q[DIV_STAGES-1]});
  assign out_side = s_q[DIV_STAGES-1];

endmodule

>>> sv/sdf_primitive_distance.sv
// Signed distance from a local-space point to one configured primitive.
// Depends on sdf_pkg, sdf_if, sdf_isqrt and sdf_div.
//
// Accepts one point every clock cycle unless the output word is held. Its
// path: two front stages, a 32-stage square root, two stages for the torus
// and cone terms, a second 32-stage square root, a 63-stage divider for the
// cone and one output register. The whole pipe advances together and halts
// while a finished word waits on the output. Users must write shape and
// parameters via the configuration port only while no point is in flight;
// this is not enforced. Values are signed Q16.16; results saturate to 32 bits.
module sdf_primitive_distance (
  input  logic        clk,
  input  logic        rst,
  sdf_point_if.sink   point,
  sdf_dist_if.source  result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sdf_pkg::*;

  // Configuration registers
  logic [2:0]         kind;
  logic signed [31:0] pa, pb, pc, pd;
  logic signed [31:0] ha, hb, hc;
  logic signed [32:0] cone_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_SPHERE;
      pa   <= Q_ONE;
      pb   <= Q_ONE;
      pc   <= Q_ONE;
      pd   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KIND:    kind <= cfg_data[2:0];
        REG_PARAM_A: pa   <= $signed(cfg_data);
        REG_PARAM_B: pb   <= $signed(cfg_data);
        REG_PARAM_C: pc   <= $signed(cfg_data);
        REG_PARAM_D: pd   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign ha     = pa >>> 1;
  assign hb     = pb >>> 1;
  assign hc     = pc >>> 1;
  assign cone_s = 33'(pa) + 33'(hb);

  // Pipe advances unless the output word is held
  logic en, out_v;
  assign en          = !out_v || result.ready;
  assign point.ready = en;

  // Front: magnitudes, box offsets and per-kind side terms
  logic [31:0]        ax, ay, az, ox, oy, oz;
  logic signed [33:0] qx, qy, qz, qmax, dy0, ymh, nyph;
  logic signed [34:0] aux0;

  function automatic logic [31:0] box_part(input logic signed [33:0] q);
    if (q < 0) begin
      return '0;
    end else if (q > 34'sh80000000) begin
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  always_comb begin
    ax   = abs32(point.point_x);
    ay   = abs32(point.point_y);
    az   = abs32(point.point_z);
    qx   = $signed({2'b00, ax}) - 34'(ha);
    qy   = $signed({2'b00, ay}) - 34'(hb);
    qz   = $signed({2'b00, az}) - 34'(hc);
    qmax = (qx > qy) ? qx : qy;
    qmax = (qz > qmax) ? qz : qmax;
    dy0  = $signed({2'b00, ay}) - 34'(hb);
    ymh  = 34'(point.point_y) - 34'(hb);
    nyph = -(34'(point.point_y) + 34'(hb));
    ox   = ax;
    oy   = ay;
    oz   = az;
    aux0 = '0;
    case (kind)
      KIND_BOX: begin
        ox   = box_part(qx);
        oy   = box_part(qy);
        oz   = box_part(qz);
        aux0 = (qmax < 0) ? 35'(qmax) : '0;
      end
      KIND_CYL: begin
        oy   = '0;
        aux0 = 35'(dy0);
      end
      KIND_CONE: begin
        oy   = '0;
        aux0 = (ymh > nyph) ? 35'(ymh) : 35'(nyph);
      end
      KIND_TORUS: oy = '0;
      default: ;
    endcase
  end

  // Stage 1: operands
  logic               v1;
  logic [2:0]         k1;
  logic [31:0]        m1x, m1y, m1z;
  logic signed [31:0] x1, y1, z1;
  logic signed [34:0] aux1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= point.valid;
    end
    if (en) begin
      k1   <= kind;
      m1x  <= ox;
      m1y  <= oy;
      m1z  <= oz;
      x1   <= point.point_x;
      y1   <= point.point_y;
      z1   <= point.point_z;
      aux1 <= aux0;
    end
  end

  // Stage 2: squares and plane products
  logic               v2;
  logic [2:0]         k2;
  logic [63:0]        sx, sy, sz;
  logic signed [63:0] p1, p2, p3;
  logic signed [31:0] y2;
  logic signed [34:0] aux2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      k2   <= k1;
      sx   <= 64'(m1x) * 64'(m1x);
      sy   <= 64'(m1y) * 64'(m1y);
      sz   <= 64'(m1z) * 64'(m1z);
      p1   <= 64'(x1) * 64'(pa);
      p2   <= 64'(y1) * 64'(pb);
      p3   <= 64'(z1) * 64'(pc);
      y2   <= y1;
      aux2 <= aux1;
    end
  end

  // Sum of squares; plane and degenerate kinds finish here
  logic [63:0]        n3;
  logic signed [65:0] psum, pfl;
  side_t              side3;

  always_comb begin
    n3   = sx + sy + sz;
    psum = 66'(p1) + 66'(p2) + 66'(p3);
    pfl  = psum >>> FRAC_BITS;
    side3      = '0;
    side3.kind = k2;
    side3.aux  = aux2;
    side3.y    = y2;
    case (k2)
      KIND_SPHERE, KIND_BOX, KIND_CYL, KIND_TORUS: ;
      KIND_PLANE: begin
        side3.fin = 1'b1;
        side3.res = sat32(68'(pfl) + 68'(pd));
      end
      KIND_CONE: begin
        if (cone_s == '0) begin
          side3.fin = 1'b1;
          side3.res = DIST_MAX;
        end
      end
      default: begin
        side3.fin = 1'b1;
        side3.res = DIST_MAX;
      end
    endcase
  end

  logic        v_a;
  logic [31:0] r1;
  side_t       side_a;

  sdf_isqrt u_sqrt_a (
    .clk, .rst, .en,
    .in_v(v2), .rad(n3), .in_side(side3),
    .out_v(v_a), .root(r1), .out_side(side_a)
  );

  // Finish sphere, box and cylinder; prepare torus and cone terms
  logic signed [33:0] r1e, dx, dxp, dyp, cmax, cmin, aux_a;
  logic [31:0]        qm_n;
  side_t              side4n;

  always_comb begin
    r1e    = $signed({2'b00, r1});
    aux_a  = $signed(side_a.aux[33:0]);
    dx     = r1e - 34'(pa);
    dxp    = (dx > 0) ? dx : '0;
    dyp    = (aux_a > 0) ? aux_a : '0;
    cmax   = (dx > aux_a) ? dx : aux_a;
    cmin   = (cmax < 0) ? cmax : '0;
    qm_n   = dx[33] ? 32'(-dx) : dx[31:0];
    side4n = side_a;
    if (!side_a.fin) begin
      case (side_a.kind)
        KIND_SPHERE: begin
          side4n.fin = 1'b1;
          side4n.res = sat32(68'(dx));
        end
        KIND_BOX: begin
          side4n.fin = 1'b1;
          side4n.res = sat32(68'(r1e) + 68'(side_a.aux));
        end
        KIND_CYL: begin
          side4n.fin = 1'b1;
          side4n.res = sat32(68'(dxp) + 68'(dyp) + 68'(cmin));
        end
        KIND_TORUS: begin
          if ((dx >= 34'sh100000000) || (dx <= -34'sh100000000)) begin
            side4n.fin = 1'b1;
            side4n.res = DIST_MAX;
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 4: torus magnitudes and cone difference
  logic               v4;
  side_t              side4;
  logic [31:0]        qm4, ym4;
  logic signed [33:0] cd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_a;
    end
    if (en) begin
      side4 <= side4n;
      qm4   <= qm_n;
      ym4   <= abs32(side_a.y);
      cd4   <= dx;
    end
  end

  // Stage 5: torus squares and cone dividend
  logic               v5;
  side_t              side5;
  logic [63:0]        tq, ty;
  logic signed [63:0] cp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      side5 <= side4;
      tq    <= 64'(qm4) * 64'(qm4);
      ty    <= 64'(ym4) * 64'(ym4);
      cp    <= 64'(66'(hb) * 66'(cd4));
    end
  end

  // Torus sum with overflow drop to the positive limit
  logic [64:0] tsum;
  side_t       side6;

  always_comb begin
    tsum      = 65'(tq) + 65'(ty);
    side6     = side5;
    side6.num = cp;
    if (!side5.fin && side5.kind == KIND_TORUS && tsum[64]) begin
      side6.fin = 1'b1;
      side6.res = DIST_MAX;
    end
  end

  logic        v_b;
  logic [31:0] r2;
  side_t       side_b;

  sdf_isqrt u_sqrt_b (
    .clk, .rst, .en,
    .in_v(v5), .rad(tsum[63:0]), .in_side(side6),
    .out_v(v_b), .root(r2), .out_side(side_b)
  );

  // Finish the torus
  side_t side7;

  always_comb begin
    side7 = side_b;
    if (!side_b.fin && side_b.kind == KIND_TORUS) begin
      side7.fin = 1'b1;
      side7.res = sat32(68'($signed({1'b0, r2})) - 68'(pb));
    end
  end

  logic               v_c;
  logic signed [63:0] quot;
  side_t              side_c;

  sdf_div u_div (
    .clk, .rst, .en,
    .in_v(v_b), .dividend(side7.num), .divisor(cone_s), .in_side(side7),
    .out_v(v_c), .quot(quot), .out_side(side_c)
  );

  // Finish the cone and pick the final word
  logic signed [31:0] axis_s, tail_s, final_d;

  always_comb begin
    axis_s  = sat32(68'(quot));
    tail_s  = sat32(68'(side_c.aux));
    final_d = side_c.fin ? side_c.res : ((axis_s > tail_s) ? axis_s : tail_s);
  end

  // Output register: hold the word until taken
  logic signed [31:0] dist_r;
  logic [2:0]         out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v_c;
    end
    if (en) begin
      dist_r   <= final_d;
      out_kind <= side_c.kind;
    end
  end

  assign result.valid    = out_v;
  assign result.distance = dist_r;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_v)
    else $error("output word valid straight after reset");

  // Unknown shape kinds give the positive limit
  a_unknown_kind: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_kind > KIND_PLANE) |-> (dist_r == DIST_MAX))
    else $error("unknown shape kind did not give the positive limit");

  // Degenerate cone gives the positive limit
  a_cone_degen: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_kind == KIND_CONE && cone_s == '0) |-> (dist_r == DIST_MAX))
    else $error("degenerate cone did not give the positive limit");

endmodule

>>> bench/sdf_distance_checker.sv
// Checker for the signed distance block: tracks the shape registers, predicts
// the distance of every accepted point and compares it with every result word.
// Depends on sdf_pkg and the point and distance channel interfaces.
module sdf_distance_checker (
  input  logic        clk,
  input  logic        rst,
  sdf_point_if        point,
  sdf_dist_if         result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  output int          pending,
  output int          errors
);
  import sdf_pkg::*;

  logic [2:0]         shape;
  logic signed [31:0] prm_a, prm_b, prm_c, prm_d;
  logic signed [31:0] expected_dist[$];

  // Floor of the square root of a 64-bit unsigned value
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_sq(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return m * m;
  endfunction

  function automatic longint clamp_part(input longint q);
    if (q < 0) return 0;
    return (q > 64'sh80000000) ? 64'sh80000000 : q;
  endfunction

  function automatic longint lmax(input longint p, input longint q);
    return (p > q) ? p : q;
  endfunction

  function automatic longint lmin(input longint p, input longint q);
    return (p < q) ? p : q;
  endfunction

  function automatic longint labs(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Unsaturated distance; the largest longint stands for "beyond the range"
  function automatic longint raw_distance(input longint x, input longint y,
                                          input longint z);
    longint a, b, c, qx, qy, qz, dx, dy, h, s, q, p1, p2, p3, h1, h2, h3, lo;
    longint unsigned acc, qq, yy;
    longint big;
    a   = longint'(prm_a);
    b   = longint'(prm_b);
    c   = longint'(prm_c);
    big = 64'sh7fffffffffffffff;
    case (shape)
      KIND_SPHERE: return longint'(floor_sqrt(mag_sq(x) + mag_sq(y) + mag_sq(z))) - a;
      KIND_BOX: begin
        qx  = labs(x) - (a >>> 1);
        qy  = labs(y) - (b >>> 1);
        qz  = labs(z) - (c >>> 1);
        acc = mag_sq(clamp_part(qx)) + mag_sq(clamp_part(qy)) + mag_sq(clamp_part(qz));
        return longint'(floor_sqrt(acc)) + lmin(lmax(qx, lmax(qy, qz)), 0);
      end
      KIND_CYL: begin
        dx = longint'(floor_sqrt(mag_sq(x) + mag_sq(z))) - a;
        dy = labs(y) - (b >>> 1);
        return lmax(dx, 0) + lmax(dy, 0) + lmin(lmax(dx, dy), 0);
      end
      KIND_CONE: begin
        h = b >>> 1;
        s = a + h;
        if (s == 0) return big;
        q = longint'(floor_sqrt(mag_sq(x) + mag_sq(z)));
        return lmax((h * (q - a)) / s, lmax(y - h, -(y + h)));
      end
      KIND_TORUS: begin
        q = longint'(floor_sqrt(mag_sq(x) + mag_sq(z))) - a;
        if (labs(q) >= 64'sh100000000) return big;
        qq = mag_sq(q);
        yy = mag_sq(y);
        if (qq + yy < qq) return big;
        return longint'(floor_sqrt(qq + yy)) - b;
      end
      KIND_PLANE: begin
        p1 = x * a;
        p2 = y * b;
        p3 = z * c;
        h1 = p1 >>> FRAC_BITS;
        h2 = p2 >>> FRAC_BITS;
        h3 = p3 >>> FRAC_BITS;
        lo = (p1 - (h1 <<< FRAC_BITS)) + (p2 - (h2 <<< FRAC_BITS))
           + (p3 - (h3 <<< FRAC_BITS));
        return h1 + h2 + h3 + (lo >>> FRAC_BITS) + longint'(prm_d);
      end
      default: return big;
    endcase
  endfunction

  function automatic logic signed [31:0] predict_distance(input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z);
    longint d;
    d = raw_distance(longint'(x), longint'(y), longint'(z));
    if (d > longint'(DIST_MAX)) return DIST_MAX;
    if (d < longint'(DIST_MIN)) return DIST_MIN;
    return d[31:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] distance check: %s", $realtime, what);
    errors++;
  endtask

  assign pending = expected_dist.size();

  // Track registers, queue predictions, compare result words
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      shape <= KIND_SPHERE;
      prm_a <= Q_ONE;
      prm_b <= Q_ONE;
      prm_c <= Q_ONE;
      prm_d <= '0;
      expected_dist.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KIND:    shape <= cfg_data[2:0];
          REG_PARAM_A: prm_a <= cfg_data;
          REG_PARAM_B: prm_b <= cfg_data;
          REG_PARAM_C: prm_c <= cfg_data;
          REG_PARAM_D: prm_d <= cfg_data;
          default: ;
        endcase
      end
      if (point.valid && point.ready)
        expected_dist.push_back(predict_distance(point.point_x, point.point_y,
                                                 point.point_z));
      if (result.valid && result.ready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", result.distance));
        end else begin
          want = expected_dist.pop_front();
          if (result.distance !== want)
            report_mismatch($sformatf("distance %0d, predicted %0d", result.distance,
                                      want));
        end
      end
    end
  end

  // Flag predictions still outstanding at the end
  initial errors = 0;
  always @(posedge done) begin
    while (expected_dist.size() > 0) begin
      report_mismatch($sformatf("no word for predicted %0d", expected_dist.pop_front()));
    end
  end

endmodule

>>> bench/tb_sdf_primitive_distance.sv
// Top of the signed distance testbench: clock, reset, shape settings, point
// stimulus with random gaps and back-pressure, and the verdict.
// Depends on sdf_pkg, the channel interfaces, the block and sdf_distance_checker.
module tb_sdf_primitive_distance;
  import sdf_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 140;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  int          pending, errors, cycles;
  bit          calm, hold_req;

  sdf_point_if pt_ch ();
  sdf_dist_if  d_ch ();

  sdf_primitive_distance uut (
    .clk(clk), .rst(rst), .point(pt_ch), .result(d_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sdf_distance_checker chk (
    .clk(clk), .rst(rst), .point(pt_ch), .result(d_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .pending(pending), .errors(errors)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sdf_primitive_distance: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, one long hold when asked
  initial begin
    int gap;
    gap = 0;
    d_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        gap = 600;
      end
      if (rst || gap > 0) begin
        d_ch.ready <= 1'b0;
        if (gap > 0) gap--;
      end else begin
        d_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write all five shape registers, then drop the enable
  task automatic set_shape(input logic [2:0] kind, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c,
                           input logic [31:0] d);
    write_reg(REG_KIND, {29'd0, kind});
    write_reg(REG_PARAM_A, a);
    write_reg(REG_PARAM_B, b);
    write_reg(REG_PARAM_C, c);
    write_reg(REG_PARAM_D, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one point and hold it until taken; idle afterwards at random
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int gap;
    pt_ch.valid   <= 1'b1;
    pt_ch.point_x <= x;
    pt_ch.point_y <= y;
    pt_ch.point_z <= z;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    pt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] pick[5];
    pick = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000};
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return pick[$urandom_range(0, 4)];
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_param();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      2:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(32'h0000_8000, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    return ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
  endfunction

  initial begin
    logic [31:0] a, b;
    logic [2:0]  kind;
    rst = 1'b1;
    done = 1'b0;
    calm = 0;
    hold_req = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pt_ch.valid = 1'b0;
    pt_ch.point_x = '0;
    pt_ch.point_y = '0;
    pt_ch.point_z = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset shape: unit sphere, origin and extremes
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    drain();

    set_shape(KIND_BOX, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0003_0000, 32'h0000_8000, 32'hffff_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();
    set_shape(KIND_CYL, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0002_0000, 32'h0003_0000, 32'h0);
    drain();
    set_shape(KIND_CONE, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0002_0000, 32'h0, 32'hfffe_0000);
    drain();
    // Degenerate cone: radius plus half height is zero
    set_shape(KIND_CONE, 32'hffff_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    // Torus, including a ring distance whose squared sum overflows
    set_shape(KIND_TORUS, 32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0);
    send_point(32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    set_shape(KIND_TORUS, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    drain();
    set_shape(KIND_PLANE, 32'h0001_0000, 32'h0, 32'h0, 32'hffff_0000);
    send_point(32'hfffd_0000, 32'h0000_1234, 32'h0);
    drain();
    set_shape(KIND_PLANE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    drain();
    // Unknown kind, and a write to an index with no register behind it
    set_shape(3'd6, 32'h0, 32'h0, 32'h0, 32'h0);
    write_reg(reg_idx_t'(3'd7), 32'hffff_ffff);
    cfg_we <= 1'b0;
    send_point(32'h0, 32'h0, 32'h0);
    drain();

    // Random phases: a fresh shape each time
    for (int ph = 0; ph < 18; ph++) begin
      kind = rand_kind();
      a = rand_param();
      b = rand_param();
      if (kind == KIND_CONE && $urandom_range(0, 3) == 0) a = -($signed(b) >>> 1);
      set_shape(kind, a, b, rand_param(), rand_param());
      calm = ($urandom_range(0, 4) == 0);
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < 80; i++) begin
        if (ph == 6 && i == 40) drain();
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end
    calm = 0;

    repeat (DRAIN_WAIT) @(posedge clk);
    done = 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("sdf_primitive_distance: match");
    end else begin
      $display("sdf_primitive_distance: mismatch");
    end
    $finish;
  end

endmodule

>>> sdf_primitive_distance.f
sv/sdf_pkg.sv
sv/sdf_if.sv
sv/sdf_isqrt.sv
sv/sdf_div.sv
sv/sdf_primitive_distance.sv
bench/sdf_distance_checker.sv
bench/tb_sdf_primitive_distance.sv
